// ===== rtl/dshot_frame_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// DShot frame scheduler assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DSHOT_FRAME_SCHEDULER_TOP_MACROS_SVH
`define DSHOT_FRAME_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define DFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// DShot frame scheduler package
// Request codes, controller states, control and status bundles, packet build.
// ----------------------------------------------------------------------------
package dfs_pkg;

    localparam int CNT_W   = 3;
    localparam int VAL_W   = 11;
    localparam int CMD_W   = 6;
    localparam int REP_W   = 4;
    localparam int PKT_W   = 16;
    localparam int SLOT_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REQ_WRITE    = 3'd0,
        REQ_TLM      = 3'd1,
        REQ_QUEUE    = 3'd2,
        REQ_UPDATE   = 3'd3,
        REQ_SHUTDOWN = 3'd4,
        REQ_DISABLE  = 3'd5,
        REQ_ENABLE   = 3'd6,
        REQ_CLEAR    = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic emit;
    } dfs_cmd_t;

    typedef struct packed {
        logic go_update;
        logic at_last;
        logic out_free;
    } dfs_status_t;

    function automatic logic [PKT_W-1:0] build_packet(input logic [VAL_W-1:0] value,
                                                      input logic tlm);
        logic [VAL_W:0] word;
        logic [3:0]     sum;
        word = {value, tlm};
        sum  = word[3:0] ^ word[7:4] ^ word[11:8];
        return {word, sum};
    endfunction

endpackage

// ===== rtl/dfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// DShot frame scheduler controller
// Accepts requests while idle and sequences packet emission of an update or shutdown.
// ----------------------------------------------------------------------------
module dfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  dfs_pkg::dfs_status_t status,
    output dfs_pkg::dfs_cmd_t    cmd,
    output logic                in_stall
);
    import dfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.go_update)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ===== rtl/dfs_datapath.sv =====
// ----------------------------------------------------------------------------
// DShot frame scheduler datapath
// Motor state, command repeat logic, slot counter and output register.
// ----------------------------------------------------------------------------
module dfs_datapath #(
    parameter int MAX_MOTORS      = 4,
    parameter int COMMAND_REPEATS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dfs_pkg::CNT_W-1:0]   cfg_active,
    output logic [dfs_pkg::CNT_W-1:0]   active_motors,
    input  dfs_pkg::dfs_cmd_t           cmd,
    output dfs_pkg::dfs_status_t        status,
    input  logic [2:0]                  req_type,
    input  logic [7:0]                  motor_index,
    input  logic [dfs_pkg::VAL_W-1:0]   throttle_value,
    input  logic [dfs_pkg::CMD_W-1:0]   command_code,
    input  logic [7:0]                  shutdown_count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dfs_pkg::SLOT_W-1:0]  motor_slot,
    output logic [dfs_pkg::PKT_W-1:0]   packet,
    output logic                        last
);
    import dfs_pkg::*;

    localparam int IDX_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;

    logic [CNT_W-1:0] active_reg;
    logic [VAL_W-1:0] values_reg [MAX_MOTORS];
    logic [VAL_W-1:0] values_next [MAX_MOTORS];
    logic [MAX_MOTORS-1:0] tlm_reg;
    logic [MAX_MOTORS-1:0] tlm_next;
    logic             enabled_reg;
    logic [CMD_W-1:0] pend_reg;
    logic [REP_W-1:0] repeats_reg;
    logic             cmd_mode_reg;
    logic [CNT_W-1:0] slot_reg;
    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [PKT_W-1:0] out_packet_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] n_c;
    logic             in_range;
    logic             do_write;
    logic             do_tlm;
    logic             do_queue;
    logic             do_shutdown;
    logic             do_disable;
    logic             do_enable;
    logic             do_clear;
    logic [IDX_W-1:0] rd_idx;
    logic [VAL_W-1:0] emit_value;
    logic             emit_tlm;

    assign n_c      = (active_reg > MAX_MOTORS) ? CNT_W'(MAX_MOTORS) : active_reg;
    assign in_range = (motor_index < n_c);

    always_comb
    begin
        do_write    = 1'b0;
        do_tlm      = 1'b0;
        do_queue    = 1'b0;
        do_shutdown = 1'b0;
        do_disable  = 1'b0;
        do_enable   = 1'b0;
        do_clear    = 1'b0;
        unique case (req_t'(req_type))
            REQ_WRITE:    do_write    = cmd.accept;
            REQ_TLM:      do_tlm      = cmd.accept;
            REQ_QUEUE:    do_queue    = cmd.accept;
            REQ_SHUTDOWN: do_shutdown = cmd.accept;
            REQ_DISABLE:  do_disable  = cmd.accept;
            REQ_ENABLE:   do_enable   = cmd.accept;
            REQ_CLEAR:    do_clear    = cmd.accept;
            default:      do_clear    = 1'b0;
        endcase
    end

    assign status.go_update = ((req_t'(req_type) == REQ_UPDATE) ||
                               (req_t'(req_type) == REQ_SHUTDOWN)) &&
                              enabled_reg && (n_c != '0);
    assign status.at_last   = ((slot_reg + CNT_W'(1)) == count_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign rd_idx     = IDX_W'(slot_reg);
    assign emit_value = cmd_mode_reg ? VAL_W'(pend_reg) : values_reg[rd_idx];
    assign emit_tlm   = cmd_mode_reg | tlm_reg[rd_idx];

    always_comb
    begin
        for (int i = 0; i < MAX_MOTORS; i++)
        begin
            values_next[i] = values_reg[i];
            tlm_next[i]    = tlm_reg[i];
            if (do_write && enabled_reg && in_range && (motor_index == i))
            begin
                values_next[i] = throttle_value;
            end
            if (do_shutdown && (i < n_c) && (i < shutdown_count))
            begin
                values_next[i] = '0;
            end
            if (do_tlm && in_range && (motor_index == i))
            begin
                tlm_next[i] = 1'b1;
            end
            if (cmd.emit && (slot_reg == i))
            begin
                tlm_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            tlm_reg       <= '0;
            enabled_reg   <= 1'b1;
            pend_reg      <= '0;
            repeats_reg   <= '0;
            cmd_mode_reg  <= 1'b0;
            slot_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_MOTORS; i++)
            begin
                values_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_active;
            end
            values_reg <= values_next;
            tlm_reg    <= tlm_next;
            if (do_disable)
            begin
                enabled_reg <= 1'b0;
            end
            if (do_enable)
            begin
                enabled_reg <= 1'b1;
            end
            if (do_queue)
            begin
                pend_reg    <= command_code;
                repeats_reg <= REP_W'(COMMAND_REPEATS);
            end
            if (do_clear)
            begin
                pend_reg    <= '0;
                repeats_reg <= '0;
            end
            if (cmd.start)
            begin
                cmd_mode_reg <= (repeats_reg != '0);
                slot_reg     <= '0;
                count_reg    <= n_c;
                if (repeats_reg != '0)
                begin
                    repeats_reg <= repeats_reg - REP_W'(1);
                end
            end
            if (cmd.emit)
            begin
                slot_reg      <= slot_reg + CNT_W'(1);
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_slot_reg   <= slot_reg[SLOT_W-1:0];
            out_packet_reg <= build_packet(emit_value, emit_tlm);
            out_last_reg   <= status.at_last;
        end
    end

    assign active_motors = active_reg;
    assign out_valid     = out_valid_reg;
    assign motor_slot    = out_slot_reg;
    assign packet        = out_packet_reg;
    assign last          = out_last_reg;

endmodule

// ===== rtl/dshot_frame_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// DShot frame scheduler
// Request channel in, DShot packet channel out, APB register for motor count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with req_type and its operands. Write,
//   telemetry, queue, disable, enable and clear requests are taken while idle and start no emission.
//   An update or shutdown with outputs enabled and a nonzero motor count
//   emits one packet per active motor on out_valid/out_stall, ascending by
//   motor_slot, with last set on the final one.
//   An accepted update or shutdown is registered into the emit state, then
//   each packet is built into one output register; the block stalls requests
//   while it emits, since a single packet builder feeds that register. A
//   finished last packet may wait in that register while the next request
//   is already accepted. A stall on the output holds the packet; emission
//   pauses until it is taken. The user is to write active_motors through
//   the APB port only while idle; the block itself does not enforce this.
//   Reset clears all motor values, telemetry flags and the pending command,
//   enables outputs and sets the motor count to zero.
// ----------------------------------------------------------------------------
module dshot_frame_scheduler_top #(
    parameter int MAX_MOTORS      = 4,
    parameter int COMMAND_REPEATS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfs_pkg::PADDR_W-1:0]   paddr,
    input  logic [dfs_pkg::PDATA_W-1:0]   pwdata,
    output logic [dfs_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    req_type,
    input  logic [7:0]                    motor_index,
    input  logic [dfs_pkg::VAL_W-1:0]     throttle_value,
    input  logic [dfs_pkg::CMD_W-1:0]     command_code,
    input  logic [7:0]                    shutdown_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dfs_pkg::SLOT_W-1:0]    motor_slot,
    output logic [dfs_pkg::PKT_W-1:0]     packet,
    output logic                          last
);
    import dfs_pkg::*;

    dfs_cmd_t         cmd;
    dfs_status_t      status;
    logic             cfg_we;
    logic [CNT_W-1:0] active_motors;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[PADDR_W-1];
    assign prdata = paddr[PADDR_W-1] ? '0 : PDATA_W'(active_motors);

    dfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    dfs_datapath #(
        .MAX_MOTORS      (MAX_MOTORS),
        .COMMAND_REPEATS (COMMAND_REPEATS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_active     (pwdata[CNT_W-1:0]),
        .active_motors  (active_motors),
        .cmd            (cmd),
        .status         (status),
        .req_type       (req_type),
        .motor_index    (motor_index),
        .throttle_value (throttle_value),
        .command_code   (command_code),
        .shutdown_count (shutdown_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .motor_slot     (motor_slot),
        .packet         (packet),
        .last           (last)
    );

endmodule

// ===== rtl/dfs_checker.sv =====
// ----------------------------------------------------------------------------
// DShot frame scheduler checker
// Port-level checks on packet hold, checksum, slot order and busy signaling.
// ----------------------------------------------------------------------------
`include "dshot_frame_scheduler_top_macros.svh"

module dfs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [dfs_pkg::SLOT_W-1:0]  motor_slot,
    input logic [dfs_pkg::PKT_W-1:0]   packet,
    input logic                        last
);
    import dfs_pkg::*;

    `DFS_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(packet) && $stable(motor_slot) && $stable(last),
        "stalled packet transaction changed")

    `DFS_ASSERT_IMP(a_checksum, out_valid,
        packet[3:0] == (packet[15:12] ^ packet[11:8] ^ packet[7:4]),
        "packet checksum mismatch")

    `DFS_ASSERT_NXT(a_slot_order, out_valid && !out_stall && !last,
        !out_valid || (motor_slot == ($past(motor_slot) + 2'd1)),
        "packet slots out of order")

    `DFS_ASSERT_IMP(a_busy_mid_frame, out_valid && !last,
        in_stall,
        "request accepted before frame finished")

endmodule

bind dshot_frame_scheduler_top dfs_checker u_dfs_checker (.*);

// ===== dv/dfs_packet_checker.sv =====
// ----------------------------------------------------------------------------
// DShot frame scheduler packet checker
// Tracks the motor-count register over APB and every accepted request, keeps
// its own copy of the scheduler state, queues the packets each request should
// produce and compares them field by field with the packets that leave the
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfs_packet_checker #(
    parameter int                           MAX_MOTORS      = 4,
    parameter int                           COMMAND_REPEATS = 10,
    parameter logic [dfs_pkg::PADDR_W-1:0]  CFG_ADDR        = '0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [dfs_pkg::PADDR_W-1:0]   paddr,
    input  logic [dfs_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [2:0]                    req_type,
    input  logic [7:0]                    motor_index,
    input  logic [dfs_pkg::VAL_W-1:0]     throttle_value,
    input  logic [dfs_pkg::CMD_W-1:0]     command_code,
    input  logic [7:0]                    shutdown_count,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [dfs_pkg::SLOT_W-1:0]    motor_slot,
    input  logic [dfs_pkg::PKT_W-1:0]     packet,
    input  logic                          last,
    output int                            errors  = 0,
    output int                            checked = 0,
    output int                            pending = 0
);

    import dfs_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [PKT_W-1:0]  word;
        logic              fin;
    } dshot_pkt_t;

    dshot_pkt_t        due_packets [$];
    logic [CNT_W-1:0]  motor_cfg;
    logic [VAL_W-1:0]  throttle_mem [MAX_MOTORS];
    logic              tlm_req      [MAX_MOTORS];
    logic              armed;
    logic [CMD_W-1:0]  cmd_word;
    logic [REP_W-1:0]  cmd_repeats;

    function automatic int motors_in_use();
        return (int'(motor_cfg) > MAX_MOTORS) ? MAX_MOTORS : int'(motor_cfg);
    endfunction

    function automatic logic [PKT_W-1:0] dshot_word(input logic [VAL_W-1:0] v,
                                                    input logic t);
        logic [11:0] body;
        logic [11:0] folded;
        body   = {v, t};
        folded = body ^ (body >> 4) ^ (body >> 8);
        return {body, folded[3:0]};
    endfunction

    function automatic void emit_frame();
        int               n;
        logic [VAL_W-1:0] v;
        logic             t;
        n = motors_in_use();
        if (!armed || n == 0)
            return;
        for (int i = 0; i < n; i++)
        begin
            v = throttle_mem[i];
            t = tlm_req[i];
            if (cmd_repeats != 0)
            begin
                v = VAL_W'(cmd_word);
                t = 1'b1;
            end
            due_packets.push_back('{slot: SLOT_W'(i), word: dshot_word(v, t),
                                    fin: (i == n - 1)});
            tlm_req[i] = 1'b0;
        end
        if (cmd_repeats != 0)
            cmd_repeats = cmd_repeats - 1'b1;
    endfunction

    function automatic void predict_request();
        int n;
        n = motors_in_use();
        case (req_t'(req_type))
            REQ_WRITE:
                if (armed && int'(motor_index) < n)
                    throttle_mem[motor_index] = throttle_value;
            REQ_TLM:
                if (int'(motor_index) < n)
                    tlm_req[motor_index] = 1'b1;
            REQ_QUEUE:
            begin
                cmd_word    = command_code;
                cmd_repeats = REP_W'(COMMAND_REPEATS);
            end
            REQ_UPDATE:
                emit_frame();
            REQ_SHUTDOWN:
            begin
                for (int i = 0; i < n && i < int'(shutdown_count); i++)
                    throttle_mem[i] = '0;
                emit_frame();
            end
            REQ_DISABLE:
                armed = 1'b0;
            REQ_ENABLE:
                armed = 1'b1;
            default:
            begin
                cmd_word    = '0;
                cmd_repeats = '0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        dshot_pkt_t want;
        if (!rst_n)
        begin
            motor_cfg   = '0;
            armed       = 1'b1;
            cmd_word    = '0;
            cmd_repeats = '0;
            for (int i = 0; i < MAX_MOTORS; i++)
            begin
                throttle_mem[i] = '0;
                tlm_req[i]      = 1'b0;
            end
            due_packets.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (due_packets.size() == 0)
                begin
                    errors++;
                    $error("unexpected transaction: motor_slot %0d packet %h last %0d",
                           motor_slot, packet, last);
                end
                else
                begin
                    want = due_packets.pop_front();
                    if (motor_slot !== want.slot)
                    begin
                        errors++;
                        $error("motor_slot: expected %0d, actual %0d", want.slot, motor_slot);
                    end
                    if (packet !== want.word)
                    begin
                        errors++;
                        $error("packet: expected %h, actual %h", want.word, packet);
                    end
                    if (last !== want.fin)
                    begin
                        errors++;
                        $error("last: expected %0d, actual %0d", want.fin, last);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == CFG_ADDR)
                motor_cfg = pwdata[CNT_W-1:0];
            if (in_valid && !in_stall)
                predict_request();
            pending <= due_packets.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// DShot frame scheduler testbench
// Drives requests and motor-count settings into the scheduler with random
// gaps and output stalls: a directed pass over every request type and corner
// case, a long output hold that backs up the request channel, then random
// phases over motor counts 1 to 7. Packets are checked by the packet checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import dfs_pkg::*;

    localparam int                    N_MOTORS   = 4;
    localparam int                    N_REPEATS  = 10;
    localparam logic [PADDR_W-1:0]    ADDR_MOTOR_COUNT = '0;
    localparam int                    LONG_HOLD  = 150;
    localparam int                    RUN_LIMIT_NS = 1000000;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [PADDR_W-1:0]  paddr          = '0;
    logic [PDATA_W-1:0]  pwdata         = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    req_t                req_type       = REQ_WRITE;
    logic [7:0]          motor_index    = '0;
    logic [VAL_W-1:0]    throttle_value = '0;
    logic [CMD_W-1:0]    command_code   = '0;
    logic [7:0]          shutdown_count = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [SLOT_W-1:0]   motor_slot;
    logic [PKT_W-1:0]    packet;
    logic                last;

    int                  errors;
    int                  checked;
    int                  pending;
    int                  requests_sent  = 0;
    int                  settings_used  = 0;
    bit                  quiet          = 1'b0;
    bit                  hold_long      = 1'b0;
    int                  cfg_seq [7]    = '{1, 3, 2, 5, 6, 4, 7};

    dshot_frame_scheduler_top #(
        .MAX_MOTORS      (N_MOTORS),
        .COMMAND_REPEATS (N_REPEATS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .motor_index    (motor_index),
        .throttle_value (throttle_value),
        .command_code   (command_code),
        .shutdown_count (shutdown_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .motor_slot     (motor_slot),
        .packet         (packet),
        .last           (last)
    );

    dfs_packet_checker #(
        .MAX_MOTORS      (N_MOTORS),
        .COMMAND_REPEATS (N_REPEATS),
        .CFG_ADDR        (ADDR_MOTOR_COUNT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .motor_index    (motor_index),
        .throttle_value (throttle_value),
        .command_code   (command_code),
        .shutdown_count (shutdown_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .motor_slot     (motor_slot),
        .packet         (packet),
        .last           (last),
        .errors         (errors),
        .checked        (checked),
        .pending        (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // hold off the packet channel in random bursts, or once for a long stretch
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_req(input req_t r, input logic [7:0] idx,
                            input logic [VAL_W-1:0] val, input logic [CMD_W-1:0] cmd,
                            input logic [7:0] sd);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= r;
        motor_index    <= idx;
        throttle_value <= val;
        command_code   <= cmd;
        shutdown_count <= sd;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    task automatic send_random();
        int   roll;
        req_t r;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            r = REQ_WRITE;
        else if (roll < 60)
            r = REQ_UPDATE;
        else if (roll < 70)
            r = REQ_TLM;
        else if (roll < 76)
            r = REQ_SHUTDOWN;
        else if (roll < 81)
            r = REQ_QUEUE;
        else if (roll < 85)
            r = REQ_DISABLE;
        else if (roll < 94)
            r = REQ_ENABLE;
        else
            r = REQ_CLEAR;
        send_req(r,
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 5)),
                 VAL_W'($urandom_range(0, 2047)),
                 CMD_W'($urandom_range(0, 63)),
                 ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 4)));
    endtask

    // drop valid and wait for every queued packet plus the block's latency
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_motor_count(input int cnt);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MOTOR_COUNT;
        pwdata  <= PDATA_W'(cnt);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_motor_count(4);
        send_req(REQ_WRITE,    8'd0,   11'd2047, 6'd0,  8'd0);
        send_req(REQ_WRITE,    8'd3,   11'd1234, 6'd63, 8'd255);
        send_req(REQ_WRITE,    8'd255, 11'd5,    6'd0,  8'd0);
        send_req(REQ_WRITE,    8'd4,   11'd77,   6'd0,  8'd0);
        send_req(REQ_TLM,      8'd1,   11'd0,    6'd0,  8'd0);
        send_req(REQ_TLM,      8'd255, 11'd2047, 6'd63, 8'd255);
        send_req(REQ_UPDATE,   8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_QUEUE,    8'd0,   11'd0,    6'd63, 8'd0);
        send_req(REQ_UPDATE,   8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_CLEAR,    8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_UPDATE,   8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_DISABLE,  8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_WRITE,    8'd1,   11'd999,  6'd0,  8'd0);
        send_req(REQ_TLM,      8'd2,   11'd0,    6'd0,  8'd0);
        send_req(REQ_UPDATE,   8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_SHUTDOWN, 8'd0,   11'd0,    6'd0,  8'd1);
        send_req(REQ_ENABLE,   8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_SHUTDOWN, 8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_QUEUE,    8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_SHUTDOWN, 8'd0,   11'd0,    6'd0,  8'd255);
        send_req(REQ_WRITE,    8'd2,   11'd0,    6'd0,  8'd0);
        send_req(REQ_UPDATE,   8'd0,   11'd0,    6'd0,  8'd0);
        drain();

        set_motor_count(0);
        send_req(REQ_UPDATE,   8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_WRITE,    8'd0,   11'd321,  6'd0,  8'd0);
        send_req(REQ_TLM,      8'd0,   11'd0,    6'd0,  8'd0);
        send_req(REQ_SHUTDOWN, 8'd0,   11'd0,    6'd0,  8'd255);
        drain();

        set_motor_count(7);
        send_req(REQ_WRITE,    8'd3,   11'd2047, 6'd0,  8'd0);
        send_req(REQ_WRITE,    8'd4,   11'd1,    6'd0,  8'd0);
        send_req(REQ_UPDATE,   8'd0,   11'd0,    6'd0,  8'd0);
        drain();

        set_motor_count(4);
        hold_long = 1'b1;
        repeat (6)
        begin
            send_req(REQ_WRITE, 8'($urandom_range(0, 3)), VAL_W'($urandom_range(0, 2047)),
                     CMD_W'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
            send_req(REQ_UPDATE, 8'($urandom_range(0, 255)), VAL_W'($urandom_range(0, 2047)),
                     CMD_W'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end
        drain();

        foreach (cfg_seq[k])
        begin
            set_motor_count(cfg_seq[k]);
            repeat (8) send_random();
            drain();
            repeat (8) send_random();
            drain();
        end

        quiet = 1'b1;
        set_motor_count(4);
        repeat (14) send_random();
        drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d requests under %0d motor-count settings, %0d packets compared",
                 requests_sent, settings_used, checked);
        $display("Mismatches: %0d, packets still owed: %0d", errors, pending);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dfs_pkg.sv
rtl/dfs_ctrl.sv
rtl/dfs_datapath.sv
rtl/dshot_frame_scheduler_top.sv
rtl/dfs_checker.sv
dv/dfs_packet_checker.sv
dv/tb.sv
